// ----- hdl/lfu_pkg.sv -----
// Shared types and constants for the LFU frame replacer.
package lfu_pkg;

   // Default build sizes
   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // Fixed field widths
   localparam int PAGE_PORT_W = 16;
   localparam int SLOT_W      = 4;
   localparam int STAMP_W     = 32;
   localparam int FAULT_W     = 32;
   localparam int FRAMES_W    = 5;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] FRAMES_IN_USE_ADDR  = 2'd0;
   localparam logic [FRAMES_W-1:0]   FRAMES_IN_USE_RESET = 5'd16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic start;    // latch the item and open a scan
      logic scan;     // issue one frame-table read
      logic update;   // write the chosen frame and load the result
   } lfu_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_last; // read being issued is the last active frame
      logic out_free;  // result register can take a new item
   } lfu_sts_type;

endpackage

// ----- hdl/lfu_ctrl.sv -----
// Sequencer for the LFU frame replacer: accept, scan, drain, update.
module lfu_ctrl
   import lfu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  lfu_sts_type sts,
   output lfu_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hdl/lfu_dpath.sv -----
// Frame table, merged hit/empty/victim scan and result register.
module lfu_dpath
   import lfu_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   input  lfu_cmd_type            cmd,
   output lfu_sts_type            sts,
   input  logic [PAGE_PORT_W-1:0] page_number,
   input  logic [FRAMES_W-1:0]    frames_in_use,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_was_hit,
   output logic [SLOT_W-1:0]      rsp_frame_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_total
);

   localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   // Frame table memories
   logic [PAGE_BITS-1:0]  tag_mem   [MAX_FRAMES];
   logic [COUNT_BITS-1:0] cnt_mem   [MAX_FRAMES];
   logic [STAMP_W-1:0]    stamp_mem [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;

   // Item state
   logic [PAGE_BITS-1:0] page_ff;
   logic [STAMP_W-1:0]   ref_clock_ff;
   logic [FAULT_W-1:0]   fault_ff;
   logic [FAULT_W-1:0]   fault_in;
   logic [IDX_W-1:0]     scan_idx_ff;
   logic [IDX_W-1:0]     last_idx;

   // Read stage
   logic                  rd_en_ff;
   logic [IDX_W-1:0]      rd_idx_ff;
   logic                  rd_valid_ff;
   logic [PAGE_BITS-1:0]  rd_tag_ff;
   logic [COUNT_BITS-1:0] rd_cnt_ff;
   logic [STAMP_W-1:0]    rd_stamp_ff;

   // Scan results
   logic                  hit_ff;
   logic [IDX_W-1:0]      hit_idx_ff;
   logic [COUNT_BITS-1:0] hit_cnt_ff;
   logic                  empty_ff;
   logic [IDX_W-1:0]      empty_idx_ff;
   logic [IDX_W-1:0]      vic_idx_ff;
   logic [COUNT_BITS-1:0] vic_cnt_ff;
   logic [STAMP_W-1:0]    vic_stamp_ff;
   logic [PAGE_BITS-1:0]  vic_tag_ff;

   logic                  take_hit;
   logic                  take_empty;
   logic                  take_vic;

   // Update values
   logic                  miss;
   logic [IDX_W-1:0]      slot;
   logic [COUNT_BITS-1:0] cnt_wr;

   // Result register
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [SLOT_W-1:0]      rsp_slot_ff;
   logic                   rsp_ev_valid_ff;
   logic [PAGE_PORT_W-1:0] rsp_ev_page_ff;
   logic [FAULT_W-1:0]     rsp_fault_ff;

   // Clamp the active frame count and turn it into the last scanned index
   always_comb begin
      if (frames_in_use == '0) begin
         last_idx = '0;
      end else if ({27'd0, frames_in_use} > 32'(MAX_FRAMES)) begin
         last_idx = IDX_W'(MAX_FRAMES - 1);
      end else begin
         last_idx = IDX_W'(frames_in_use - 5'd1);
      end
   end

   assign sts.scan_last = (scan_idx_ff == last_idx);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   // Latch the page, advance the reference clock, step the scan counter
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         page_ff <= PAGE_BITS'(page_number);
      end
      if (cmd.start) begin
         scan_idx_ff <= '0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff <= '0;
      end else if (cmd.start && (ref_clock_ff != '1)) begin
         ref_clock_ff <= ref_clock_ff + 1'b1;
      end
   end

   // Registered table reads, one frame a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_en_ff <= 1'b0;
      end else begin
         rd_en_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         rd_idx_ff   <= scan_idx_ff;
         rd_valid_ff <= valid_ff[scan_idx_ff];
         rd_tag_ff   <= tag_mem[scan_idx_ff];
         rd_cnt_ff   <= cnt_mem[scan_idx_ff];
         rd_stamp_ff <= stamp_mem[scan_idx_ff];
      end
   end

   // Compare the read frame against the running best picks
   assign take_hit   = rd_en_ff && rd_valid_ff && !hit_ff && (rd_tag_ff == page_ff);
   assign take_empty = rd_en_ff && !rd_valid_ff && !empty_ff;
   assign take_vic   = rd_en_ff && ((rd_idx_ff == '0) ||
                                    (rd_cnt_ff < vic_cnt_ff) ||
                                    ((rd_cnt_ff == vic_cnt_ff) &&
                                     (rd_stamp_ff < vic_stamp_ff)));

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         hit_ff   <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         if (take_hit) begin
            hit_ff <= 1'b1;
         end
         if (take_empty) begin
            empty_ff <= 1'b1;
         end
      end
      if (take_hit) begin
         hit_idx_ff <= rd_idx_ff;
         hit_cnt_ff <= rd_cnt_ff;
      end
      if (take_empty) begin
         empty_idx_ff <= rd_idx_ff;
      end
      if (take_vic) begin
         vic_idx_ff   <= rd_idx_ff;
         vic_cnt_ff   <= rd_cnt_ff;
         vic_stamp_ff <= rd_stamp_ff;
         vic_tag_ff   <= rd_tag_ff;
      end
   end

   // Pick the frame and the values to write
   assign miss = !hit_ff;

   always_comb begin
      if (hit_ff) begin
         slot = hit_idx_ff;
      end else if (empty_ff) begin
         slot = empty_idx_ff;
      end else begin
         slot = vic_idx_ff;
      end
   end

   always_comb begin
      if (!hit_ff) begin
         cnt_wr = COUNT_BITS'(1);
      end else if (hit_cnt_ff == '1) begin
         cnt_wr = hit_cnt_ff;
      end else begin
         cnt_wr = hit_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      fault_in = fault_ff;
      if (miss && (fault_ff != '1)) begin
         fault_in = fault_ff + 1'b1;
      end
   end

   // Table writes
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         cnt_mem[slot] <= cnt_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && miss) begin
         tag_mem[slot] <= page_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && miss) begin
         stamp_mem[slot] <= ref_clock_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fault_ff <= '0;
      end else if (cmd.update) begin
         fault_ff <= fault_in;
         if (miss) begin
            valid_ff[slot] <= 1'b1;
         end
      end
   end

   // Result register: load on update, hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.update) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_hit_ff      <= hit_ff;
         rsp_slot_ff     <= SLOT_W'(slot);
         rsp_ev_valid_ff <= miss && !empty_ff;
         rsp_ev_page_ff  <= (miss && !empty_ff) ? PAGE_PORT_W'(vic_tag_ff) : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_hit       = rsp_hit_ff;
   assign rsp_frame_slot    = rsp_slot_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_fault_ff;

endmodule

// ----- hdl/lfu_frame_replacer.sv -----
// LFU frame replacer with oldest-load tie break. Each page reference item is
// checked against up to MAX_FRAMES frames by one scan that reads one frame per
// cycle from the frame table and finds the hit, the first empty frame and the
// least-used, oldest-loaded victim together. With n active frames (frames_in_use,
// 0 taken as 1 and clamped to MAX_FRAMES) an item is accepted, then n table reads
// are issued, the last read is compared, and a write-back updates the table and
// loads the result; the next item can be accepted in the cycle after the
// write-back. The write-back waits while the output register still holds an
// untaken result. One item is worked on at a time; the next one is accepted
// while the previous result still waits in the output register. frames_in_use
// sits at byte address 0.
module lfu_frame_replacer
   import lfu_pkg::*;
#(
   parameter int MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
)(
   input  logic                   clock,
   input  logic                   reset,
   // Reference items
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [PAGE_PORT_W-1:0] req_page_number,
   // Result items
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_was_hit,
   output logic [SLOT_W-1:0]      rsp_frame_slot,
   output logic                   rsp_evicted_valid,
   output logic [PAGE_PORT_W-1:0] rsp_evicted_page,
   output logic [FAULT_W-1:0]     rsp_fault_total,
   // Configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   lfu_cmd_type         cmd;
   lfu_sts_type         sts;
   logic [FRAMES_W-1:0] frames_ff;

   // Configuration register: a single 5-bit register in the low bits of the word, written at any address
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_IN_USE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         frames_ff <= csr_pwdata[FRAMES_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr == FRAMES_IN_USE_ADDR) ?
                       CSR_DATA_W'(frames_ff) : '0;

   lfu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lfu_dpath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .page_number       (req_page_number),
      .frames_in_use     (frames_ff),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_was_hit       (rsp_was_hit),
      .rsp_frame_slot    (rsp_frame_slot),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule
